>>> sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle
`define APOT_ASSERT_NOW(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("same-cycle check failed");

// Check that a condition implies another in the next cycle
`define APOT_ASSERT_NEXT(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("next-cycle check failed");

`endif

>>> sv/apot_pkg.sv
package apot_pkg;

	localparam int MAX_ENTRIES   = 64;
	localparam int IDX_W         = $clog2(MAX_ENTRIES);
	localparam int HOST_TAG_BITS = 16;
	localparam int ADDR_W        = 64;
	localparam int ENTRY_W       = 2 * ADDR_W + HOST_TAG_BITS;

	// Request opcodes
	localparam logic [1:0] OP_OCCUPY  = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_LOOKUP  = 2'd2;
	localparam logic [1:0] OP_SPARE   = 2'd3;

	// Result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_RANGE     = 3'd1;
	localparam logic [2:0] ST_OCCUPIED  = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;

	// Register indexes
	localparam logic [2:0] REG_FAMILY  = 3'd0;
	localparam logic [2:0] REG_FIRST_H = 3'd1;
	localparam logic [2:0] REG_FIRST_L = 3'd2;
	localparam logic [2:0] REG_LAST_H  = 3'd3;
	localparam logic [2:0] REG_LAST_L  = 3'd4;

	typedef struct packed {
		logic              family;
		logic [ADDR_W-1:0] first_h;
		logic [ADDR_W-1:0] first_l;
		logic [ADDR_W-1:0] last_h;
		logic [ADDR_W-1:0] last_l;
	} cfg_t;

	typedef struct packed {
		logic [1:0]               op;
		logic [ADDR_W-1:0]        ah;
		logic [ADDR_W-1:0]        al;
		logic [HOST_TAG_BITS-1:0] tag;
		logic                     in_range;
	} req_t;

	typedef struct packed {
		logic empty;
	} qstat_t;

endpackage

>>> sv/apot_ram.sv
module apot_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write or read one entry per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

>>> sv/apot_front.sv
module apot_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  apot_pkg::cfg_t                    cfg,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        opcode,
	input  logic [apot_pkg::ADDR_W-1:0]       addr_high,
	input  logic [apot_pkg::ADDR_W-1:0]       addr_low,
	input  logic [apot_pkg::HOST_TAG_BITS-1:0] host_tag,
	input  logic                              pop,
	output apot_pkg::req_t                    req,
	output apot_pkg::qstat_t                  qstat
);
	import apot_pkg::*;

	logic [2*ADDR_W-1:0] a_w, f_w, l_w;
	req_t                new_req;
	req_t                fifo_q [2];
	logic                wr_ptr_q, rd_ptr_q;
	logic [1:0]          count_q;
	logic                push;

	// Narrow addresses and bounds to 32 bits for IPv4, and mark whether the address is in range
	always_comb begin
		if (cfg.family) begin
			a_w = {addr_high, addr_low};
			f_w = {cfg.first_h, cfg.first_l};
			l_w = {cfg.last_h, cfg.last_l};
		end else begin
			a_w = {96'd0, addr_low[31:0]};
			f_w = {96'd0, cfg.first_l[31:0]};
			l_w = {96'd0, cfg.last_l[31:0]};
		end
		new_req.op       = opcode;
		new_req.ah       = a_w[2*ADDR_W-1:ADDR_W];
		new_req.al       = a_w[ADDR_W-1:0];
		new_req.tag      = host_tag;
		new_req.in_range = !(a_w < f_w) && !(a_w > l_w);
	end

	assign in_stall    = (count_q == 2'd2);
	assign push        = in_valid && !in_stall;
	assign req         = fifo_q[rd_ptr_q];
	assign qstat.empty = (count_q == 2'd0);

	// Hold classified requests for the back end
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= new_req;
		end
	end

	// Advance queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

>>> sv/apot_back.sv
module apot_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  apot_pkg::req_t                     req,
	input  apot_pkg::qstat_t                   qstat,
	output logic                               pop,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [2:0]                         status,
	output logic                               is_occupied,
	output logic [apot_pkg::HOST_TAG_BITS-1:0] owner_tag
);
	import apot_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_WAIT = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0]               state_q;
	req_t                     req_q;
	logic [IDX_W-1:0]         cnt_q;
	logic                     cmp_s1;
	logic [IDX_W-1:0]         idx_s1;
	logic [MAX_ENTRIES-1:0]   valid_q;
	logic                     hit_q, free_q;
	logic [IDX_W-1:0]         hit_idx_q, free_idx_q;
	logic [HOST_TAG_BITS-1:0] hit_owner_q;
	logic                     out_valid_q;
	logic [2:0]               status_q;
	logic                     occ_q;
	logic [HOST_TAG_BITS-1:0] owner_q;

	logic                     fin_go, ram_we, match, empty_slot;
	logic [IDX_W-1:0]         ram_addr;
	logic [ENTRY_W-1:0]       ram_rdata;

	assign pop        = (state_q == S_IDLE) && !qstat.empty;
	assign fin_go     = (state_q == S_FIN) && (!out_valid_q || !out_stall);
	assign ram_we     = fin_go && req_q.in_range && (req_q.op == OP_OCCUPY) && !hit_q && free_q;
	assign ram_addr   = (state_q == S_FIN) ? free_idx_q : cnt_q;
	assign match      = cmp_s1 && valid_q[idx_s1]
		&& (ram_rdata[ENTRY_W-1 -: ADDR_W] == req_q.ah)
		&& (ram_rdata[HOST_TAG_BITS +: ADDR_W] == req_q.al);
	assign empty_slot = cmp_s1 && !valid_q[idx_s1];

	apot_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ENTRIES)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata ({req_q.ah, req_q.al, req_q.tag}),
		.rdata (ram_rdata)
	);

	// Take a request from the queue and record the matching entry and the first free slot
	always_ff @(posedge clk) begin
		if (pop) begin
			req_q <= req;
		end
		idx_s1 <= cnt_q;
		if (match) begin
			hit_idx_q   <= idx_s1;
			hit_owner_q <= ram_rdata[HOST_TAG_BITS-1:0];
		end
		if (empty_slot && !free_q) begin
			free_idx_q <= idx_s1;
		end
	end

	// Sequence the table scan and commit the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			cmp_s1      <= 1'b0;
			valid_q     <= '0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			out_valid_q <= 1'b0;
			status_q    <= ST_OK;
			occ_q       <= 1'b0;
			owner_q     <= '0;
		end else begin
			cmp_s1 <= (state_q == S_SCAN);
			if (match) begin
				hit_q <= 1'b1;
			end
			if (empty_slot) begin
				free_q <= 1'b1;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						hit_q   <= 1'b0;
						free_q  <= 1'b0;
						cnt_q   <= '0;
						state_q <= req.in_range ? S_SCAN : S_FIN;
					end
				end
				S_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == IDX_W'(MAX_ENTRIES - 1)) begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (!cmp_s1) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_go) begin
						out_valid_q <= 1'b1;
						occ_q       <= 1'b0;
						owner_q     <= '0;
						state_q     <= S_IDLE;
						if (!req_q.in_range) begin
							status_q <= ST_RANGE;
						end else begin
							case (req_q.op)
								OP_OCCUPY: begin
									if (hit_q) begin
										status_q <= ST_OCCUPIED;
									end else if (free_q) begin
										status_q            <= ST_OK;
										valid_q[free_idx_q] <= 1'b1;
									end else begin
										status_q <= ST_FULL;
									end
								end
								OP_RELEASE: begin
									if (hit_q) begin
										status_q           <= ST_OK;
										valid_q[hit_idx_q] <= 1'b0;
									end else begin
										status_q <= ST_NOT_FOUND;
									end
								end
								default: begin
									status_q <= ST_OK;
									occ_q    <= hit_q;
									owner_q  <= hit_q ? hit_owner_q : '0;
								end
							endcase
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign is_occupied = occ_q;
	assign owner_tag   = owner_q;

endmodule

>>> sv/address_pool_occupancy_table.sv
// Address pool occupancy table.
// Input channel (in_valid/in_stall): opcode, addr_high, addr_low, host_tag.
// Each transfer occupies, releases or looks up one address of the pool set
// through the APB registers (family, first and last address of the range).
// Output channel (out_valid/out_stall): status, is_occupied, owner_tag, one
// result per request, in request order.
// The front end checks the range and places the request in a two-deep queue;
// the back end scans the 64-entry table memory, one entry a cycle.
// An in-range request goes through the queue, the table scan over the single
// memory port, a wait and a finish state; an out-of-range one skips the scan.
// The back end takes no new request until the last result is committed.
// While the receiver stalls, the result is held and the queue keeps taking
// up to two more requests before in_stall rises.
// Reset empties the table and queue and zeroes the control and config registers.
// Configure only while no request is in flight.
`include "assert_macros.svh"

module address_pool_occupancy_table (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [5:0]                         paddr,
	input  logic [63:0]                        pwdata,
	output logic [63:0]                        prdata,
	output logic                               pready,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         opcode,
	input  logic [apot_pkg::ADDR_W-1:0]        addr_high,
	input  logic [apot_pkg::ADDR_W-1:0]        addr_low,
	input  logic [apot_pkg::HOST_TAG_BITS-1:0] host_tag,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [2:0]                         status,
	output logic                               is_occupied,
	output logic [apot_pkg::HOST_TAG_BITS-1:0] owner_tag
);
	import apot_pkg::*;

	cfg_t       cfg_q;
	req_t       req;
	qstat_t     qstat;
	logic       pop;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[5:3];

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_FAMILY:  cfg_q.family  <= pwdata[0];
				REG_FIRST_H: cfg_q.first_h <= pwdata;
				REG_FIRST_L: cfg_q.first_l <= pwdata;
				REG_LAST_H:  cfg_q.last_h  <= pwdata;
				REG_LAST_L:  cfg_q.last_l  <= pwdata;
				default: ;
			endcase
		end
	end

	// Read back configuration registers
	always_comb begin
		case (reg_idx)
			REG_FAMILY:  prdata = {63'd0, cfg_q.family};
			REG_FIRST_H: prdata = cfg_q.first_h;
			REG_FIRST_L: prdata = cfg_q.first_l;
			REG_LAST_H:  prdata = cfg_q.last_h;
			REG_LAST_L:  prdata = cfg_q.last_l;
			default:     prdata = '0;
		endcase
	end

	apot_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.addr_high (addr_high),
		.addr_low  (addr_low),
		.host_tag  (host_tag),
		.pop       (pop),
		.req       (req),
		.qstat     (qstat)
	);

	apot_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.qstat       (qstat),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.is_occupied (is_occupied),
		.owner_tag   (owner_tag)
	);

	`APOT_ASSERT_NEXT(a_push_fills_queue, in_valid && !in_stall, !qstat.empty)
	`APOT_ASSERT_NOW(a_pop_not_empty, pop, !qstat.empty)
	`APOT_ASSERT_NOW(a_occ_means_ok, out_valid && is_occupied, status == ST_OK)
	`APOT_ASSERT_NOW(a_owner_needs_occ, out_valid && (owner_tag != '0), is_occupied)

endmodule

>>> test/address_pool_occupancy_table_checker.sv
`timescale 1ns / 100ps

module address_pool_occupancy_table_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [5:0]                         paddr,
	input  logic [63:0]                        pwdata,
	input  logic                               pready,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  logic [1:0]                         opcode,
	input  logic [apot_pkg::ADDR_W-1:0]        addr_high,
	input  logic [apot_pkg::ADDR_W-1:0]        addr_low,
	input  logic [apot_pkg::HOST_TAG_BITS-1:0] host_tag,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  logic [2:0]                         status,
	input  logic                               is_occupied,
	input  logic [apot_pkg::HOST_TAG_BITS-1:0] owner_tag,
	output int                                 errors,
	output int                                 pending
);
	import apot_pkg::*;

	typedef struct packed {
		logic [2:0]               st;
		logic                     occ;
		logic [HOST_TAG_BITS-1:0] owner;
	} outcome_t;

	// Shadow of the pool registers
	logic              fam;
	logic [ADDR_W-1:0] first_h, first_l, last_h, last_l;

	// Shadow of the occupancy table
	logic                     slot_used  [MAX_ENTRIES];
	logic [2*ADDR_W-1:0]      slot_addr  [MAX_ENTRIES];
	logic [HOST_TAG_BITS-1:0] slot_owner [MAX_ENTRIES];

	outcome_t expected_results[$];

	assign pending = expected_results.size();

	// Work out the outcome of one request and update the table shadow
	function automatic outcome_t apply_request(logic [1:0] op, logic [ADDR_W-1:0] ah,
			logic [ADDR_W-1:0] al, logic [HOST_TAG_BITS-1:0] tag);
		logic [2*ADDR_W-1:0] a, lo, hi;
		outcome_t            r;
		int                  hit;
		a   = {ah, al};
		lo  = {first_h, first_l};
		hi  = {last_h, last_l};
		r   = '0;
		hit = -1;
		if (!fam) begin
			a  = {96'd0, al[31:0]};
			lo = {96'd0, first_l[31:0]};
			hi = {96'd0, last_l[31:0]};
		end
		if (a < lo || a > hi) begin
			r.st = ST_RANGE;
			return r;
		end
		for (int i = 0; i < MAX_ENTRIES; i++)
			if (hit < 0 && slot_used[i] && slot_addr[i] == a)
				hit = i;
		r.st = ST_OK;
		if (op == OP_OCCUPY) begin
			if (hit >= 0) begin
				r.st = ST_OCCUPIED;
			end else begin
				r.st = ST_FULL;
				for (int i = 0; i < MAX_ENTRIES; i++)
					if (r.st == ST_FULL && !slot_used[i]) begin
						slot_used[i]  = 1'b1;
						slot_addr[i]  = a;
						slot_owner[i] = tag;
						r.st          = ST_OK;
					end
			end
		end else if (op == OP_RELEASE) begin
			if (hit >= 0)
				slot_used[hit] = 1'b0;
			else
				r.st = ST_NOT_FOUND;
		end else if (hit >= 0) begin
			// lookup, and the spare opcode behaves the same
			r.occ   = 1'b1;
			r.owner = slot_owner[hit];
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t got, exp_r;
		if (!arst_n) begin
			fam     <= 1'b0;
			first_h <= '0;
			first_l <= '0;
			last_h  <= '0;
			last_l  <= '0;
			errors  <= 0;
			for (int i = 0; i < MAX_ENTRIES; i++)
				slot_used[i] = 1'b0;
			expected_results.delete();
		end else begin
			// Track register writes
			if (psel && penable && pwrite && pready) begin
				case (paddr[5:3])
					REG_FAMILY:  fam     <= pwdata[0];
					REG_FIRST_H: first_h <= pwdata;
					REG_FIRST_L: first_l <= pwdata;
					REG_LAST_H:  last_h  <= pwdata;
					REG_LAST_L:  last_l  <= pwdata;
					default: ;
				endcase
			end
			// Predict on each request transfer
			if (in_valid && !in_stall)
				expected_results.push_back(apply_request(opcode, addr_high, addr_low,
					host_tag));
			// Compare each result transfer with the oldest expectation
			if (out_valid && !out_stall) begin
				got = {status, is_occupied, owner_tag};
				if (expected_results.size() == 0) begin
					$error("unexpected result: status %0d is_occupied %0d owner_tag %h",
						status, is_occupied, owner_tag);
					errors <= errors + 1;
				end else begin
					exp_r = expected_results.pop_front();
					if (got.st !== exp_r.st)
						$error("status: expected %0d, got %0d", exp_r.st, got.st);
					if (got.occ !== exp_r.occ)
						$error("is_occupied: expected %0d, got %0d", exp_r.occ, got.occ);
					if (got.owner !== exp_r.owner)
						$error("owner_tag: expected %h, got %h", exp_r.owner, got.owner);
					if (got !== exp_r)
						errors <= errors + 1;
				end
			end
		end
	end

endmodule

>>> test/address_pool_occupancy_table_tb.sv
`timescale 1ns / 100ps

module address_pool_occupancy_table_tb;
	import apot_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;

	logic                     clk;
	logic                     arst_n;
	logic                     psel, penable, pwrite;
	logic [5:0]               paddr;
	logic [63:0]              pwdata, prdata;
	logic                     pready;
	logic                     in_valid, in_stall;
	logic [1:0]               opcode;
	logic [ADDR_W-1:0]        addr_high, addr_low;
	logic [HOST_TAG_BITS-1:0] host_tag;
	logic                     out_valid, out_stall;
	logic [2:0]               status;
	logic                     is_occupied;
	logic [HOST_TAG_BITS-1:0] owner_tag;
	int                       errors, pending;
	int                       gap_pct, stall_pct;
	int                       cycles;

	address_pool_occupancy_table u_dut (.*);

	address_pool_occupancy_table_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Random receiver stall
	always @(posedge clk)
		out_stall <= ($urandom_range(0, 99) < stall_pct);

	// Give up on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic reg_write(logic [2:0] idx, logic [63:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_pool(logic f, logic [127:0] first, logic [127:0] last);
		reg_write(REG_FAMILY, {63'd0, f});
		reg_write(REG_FIRST_H, first[127:64]);
		reg_write(REG_FIRST_L, first[63:0]);
		reg_write(REG_LAST_H, last[127:64]);
		reg_write(REG_LAST_L, last[63:0]);
	endtask

	// Hold the request until it is transferred; leave valid high for the next one
	task automatic send_request(logic [1:0] op, logic [127:0] a, logic [15:0] tag);
		bit taken;
		while ($urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		opcode    <= op;
		addr_high <= a[127:64];
		addr_low  <= a[63:0];
		host_tag  <= tag;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (80) @(posedge clk);
	endtask

	function automatic logic [127:0] rand128();
		return {$urandom, $urandom, $urandom, $urandom};
	endfunction

	// Mostly addresses inside a small window so the table fills and drains
	task automatic run_pool(int n, int mode, logic f, logic [127:0] first,
			logic [127:0] last, logic [127:0] base, int span, int occupy_pct);
		logic [127:0] a;
		logic [1:0]   op;
		int           r;
		gap_pct   = (mode == 1) ? 83 : (mode == 3) ? 8 : 0;
		stall_pct = (mode == 2) ? 83 : (mode == 3) ? 8 : 0;
		set_pool(f, first, last);
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 85)
				a = base + $urandom_range(0, span);
			else if (r < 90)
				a = first - 1;
			else if (r < 95)
				a = last + 1;
			else
				a = rand128();
			// upper bits are don't-care in IPv4 mode
			if (!f && $urandom_range(0, 1))
				a[127:32] = 96'(rand128());
			r = $urandom_range(0, 99);
			if (r < occupy_pct)
				op = OP_OCCUPY;
			else if (r < occupy_pct + (100 - occupy_pct) / 2)
				op = OP_RELEASE;
			else
				op = $urandom_range(0, 1) ? OP_LOOKUP : OP_SPARE;
			send_request(op, a, 16'($urandom));
		end
		drain();
	endtask

	initial begin
		logic [127:0] b;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		in_valid  = 1'b0;
		opcode    = OP_OCCUPY;
		addr_high = '0;
		addr_low  = '0;
		host_tag  = '0;
		gap_pct   = 0;
		stall_pct = 0;
		arst_n    = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset range holds only address zero
		send_request(OP_OCCUPY, 128'd0, 16'h1234);
		send_request(OP_LOOKUP, 128'd1, 16'h0);
		send_request(OP_RELEASE, 128'd0, 16'h0);
		drain();

		// Directed IPv4 checks; upper bits of the bounds are masked off
		set_pool(1'b0, {64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_0000_0010},
			{64'h0, 64'h0000_0000_0000_0020});
		send_request(OP_OCCUPY, 128'h10, 16'hFFFF);
		send_request(OP_OCCUPY, 128'h10, 16'h0000);
		send_request(OP_LOOKUP, 128'h10, 16'h0);
		send_request(OP_SPARE, 128'h10, 16'h0);
		send_request(OP_RELEASE, 128'h10, 16'h0);
		send_request(OP_RELEASE, 128'h10, 16'h0);
		send_request(OP_LOOKUP, 128'h10, 16'h0);
		send_request(OP_LOOKUP, 128'hF, 16'h0);
		send_request(OP_OCCUPY, 128'h21, 16'h0);
		send_request(OP_OCCUPY, 128'h20, 16'hA5A5);
		send_request(OP_OCCUPY, {64'hFFFF_FFFF_FFFF_FFFF, 64'hABCD_0000_0000_0015},
			16'h5A5A);
		send_request(OP_LOOKUP, 128'h15, 16'h0);
		send_request(OP_LOOKUP, {64'h0, 64'hFFFF_FFFF_FFFF_FFFF}, 16'h0);
		send_request(OP_RELEASE, 128'h20, 16'h0);
		drain();

		// Random phases across several pool settings
		b = rand128();
		b[127:32] = '0;
		b[31:0] = b[31:0] & 32'hFFFF_FF00;
		run_pool(150, 0, 1'b0, b, b + 70, b, 80, 70);
		b = rand128();
		run_pool(150, 1, 1'b1, b, b + 100, b, 110, 60);
		b = rand128();
		run_pool(150, 2, 1'b1, 128'd0, {128{1'b1}}, b, 90, 65);
		b = rand128();
		run_pool(120, 3, 1'b1, b + 50, b, b - 5, 60, 50);
		b = rand128();
		b[127:32] = '0;
		run_pool(150, 0, 1'b0, 128'd0, 128'hFFFF_FFFF, b, 90, 60);
		b = rand128();
		run_pool(100, 1, 1'b1, b, b, b - 2, 4, 50);
		b = rand128();
		b[127:32] = '0;
		run_pool(150, 2, 1'b0, b, b + 200, b, 200, 45);
		run_pool(150, 3, 1'b1, {128{1'b1}} - 80, {128{1'b1}}, {128{1'b1}} - 85, 85, 70);

		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
